// ===== design/conv3x3_zero_padded_core_assert.svh =====
// Assertion macros for the 3x3 convolution core.
`ifndef CONV3X3_ZERO_PADDED_CORE_ASSERT_SVH
`define CONV3X3_ZERO_PADDED_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define C3ZP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("c3zp assertion failed");

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low.
`define C3ZP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("c3zp assertion failed");

`else

`define C3ZP_ASSERT_NOW(label, ante, cons)
`define C3ZP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== design/c3zp_pkg.sv =====
// Shared constants, types and helpers of the 3x3 convolution core.
`timescale 1ns / 1ps

package c3zp_pkg;

    // Line store depth: widest supported row.
    localparam int MAX_WIDTH     = 512;
    localparam int HEIGHT_CAP    = 1022;
    localparam int DIM_W         = 10;
    localparam int ADDR_W        = $clog2(MAX_WIDTH);
    localparam int MAXW_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int WID_W         = (DIM_W > MAXW_BITS) ? DIM_W : MAXW_BITS;
    localparam int WIDTH_RESET   = 512;
    localparam int HEIGHT_RESET  = 512;

    localparam int PIX_W         = 8;
    localparam int TAP_W         = 8;
    localparam int COEF_W        = 24;
    localparam int SHIFT_W       = 3;
    localparam int IDX_W         = 3;
    localparam int PROD_W        = PIX_W + 1 + TAP_W;
    localparam int COLSUM_W      = PROD_W + 2;
    localparam int RES_W         = 20;

    // Front-to-back job queue.
    localparam int QDEPTH        = 4;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_COEF_TOP = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_COEF_MID = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_COEF_BOT = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SHIFT    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_WIDTH    = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_HEIGHT   = IDX_W'(5);

    typedef struct packed {
        logic [COEF_W-1:0]  coef_top;
        logic [COEF_W-1:0]  coef_mid;
        logic [COEF_W-1:0]  coef_bot;
        logic [SHIFT_W-1:0] shift;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_cfg;

    // Masked 3x3 neighbourhood, entry k*3+j = column k (oldest first), row j (top first).
    typedef struct packed {
        logic [8:0][PIX_W-1:0] pix;
        logic                  last;
    } t_job;

    // Kernel tap at row krow, column kcol.
    function automatic logic signed [TAP_W-1:0] kernel_tap(t_cfg cfg, int krow, int kcol);
        logic [COEF_W-1:0] row_bits;
        begin
            if (krow == 0) begin
                row_bits = cfg.coef_top;
            end else if (krow == 1) begin
                row_bits = cfg.coef_mid;
            end else begin
                row_bits = cfg.coef_bot;
            end
            return $signed(row_bits[TAP_W*kcol +: TAP_W]);
        end
    endfunction

endpackage

// ===== design/c3zp_front.sv =====
// Front end: raster position tracking, line stores, window and job classification.
`timescale 1ns / 1ps

module c3zp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [c3zp_pkg::PIX_W-1:0]      i_pixel,
    input  logic                            i_flush,
    input  c3zp_pkg::t_cfg                  i_cfg,
    input  logic [c3zp_pkg::QCNT_W-1:0]     i_q_free,
    output logic                            o_job_valid,
    output c3zp_pkg::t_job                  o_job
);

    logic [c3zp_pkg::PIX_W-1:0] r_line_upper [c3zp_pkg::MAX_WIDTH];
    logic [c3zp_pkg::PIX_W-1:0] r_line_lower [c3zp_pkg::MAX_WIDTH];
    logic [c3zp_pkg::PIX_W-1:0] r_up_rd, r_mid_rd;

    logic [c3zp_pkg::WID_W-1:0] r_col, n_col;
    logic [c3zp_pkg::DIM_W-1:0] r_row, n_row;

    logic [2:0][2:0][c3zp_pkg::PIX_W-1:0] r_win;

    logic                        r_s1_valid;
    logic [c3zp_pkg::ADDR_W-1:0] r_s1_addr;
    logic [c3zp_pkg::PIX_W-1:0]  r_s1_pix;
    logic                        r_s1_emit;
    logic                        r_s1_last;
    logic [2:0]                  r_s1_cmask;
    logic [2:0]                  r_s1_rmask;
    logic                        r_s1_byp;
    logic [c3zp_pkg::PIX_W-1:0]  r_byp_up, r_byp_mid;

    logic                        accept;
    logic [c3zp_pkg::WID_W-1:0]  w_eff;
    logic [c3zp_pkg::DIM_W-1:0]  h_eff, h_p1;
    logic                        restart;
    logic [c3zp_pkg::WID_W-1:0]  cur_col;
    logic [c3zp_pkg::DIM_W-1:0]  cur_row;
    logic [c3zp_pkg::ADDR_W-1:0] addr;
    logic [c3zp_pkg::PIX_W-1:0]  pix_in;
    logic                        row_end, in_row;
    logic [2:0]                  cmask, rmask;
    logic [c3zp_pkg::PIX_W-1:0]  up_e, mid_e;
    logic [2:0][c3zp_pkg::PIX_W-1:0] new_col;

    assign accept = i_valid && o_ready;
    assign o_ready = i_q_free > c3zp_pkg::QCNT_W'(r_s1_valid);

    // Effective frame size
    always_comb begin
        if (i_cfg.width == '0) begin
            w_eff = c3zp_pkg::WID_W'(1);
        end else if (c3zp_pkg::WID_W'(i_cfg.width) > c3zp_pkg::WID_W'(c3zp_pkg::MAX_WIDTH)) begin
            w_eff = c3zp_pkg::WID_W'(c3zp_pkg::MAX_WIDTH);
        end else begin
            w_eff = c3zp_pkg::WID_W'(i_cfg.width);
        end
        if (i_cfg.height == '0) begin
            h_eff = c3zp_pkg::DIM_W'(1);
        end else if (i_cfg.height > c3zp_pkg::DIM_W'(c3zp_pkg::HEIGHT_CAP)) begin
            h_eff = c3zp_pkg::DIM_W'(c3zp_pkg::HEIGHT_CAP);
        end else begin
            h_eff = i_cfg.height;
        end
        h_p1 = h_eff + c3zp_pkg::DIM_W'(1);
    end

    // Position and classification of the item on the input port
    always_comb begin
        restart = (r_col >= w_eff) || (r_row > h_p1);
        cur_col = restart ? '0 : r_col;
        cur_row = restart ? '0 : r_row;
        addr    = cur_col[c3zp_pkg::ADDR_W-1:0];
        pix_in  = i_flush ? '0 : i_pixel;

        // row_end: closes the last pixel of row cur_row-2 from the old window
        row_end = (cur_col == '0) && (cur_row >= c3zp_pkg::DIM_W'(2));
        in_row  = (cur_col != '0) && (cur_row != '0) && (cur_row <= h_eff);

        if (row_end) begin
            cmask = {1'b0, 1'b1, w_eff >= c3zp_pkg::WID_W'(2)};
            rmask = {cur_row <= h_eff, 1'b1, cur_row >= c3zp_pkg::DIM_W'(3)};
        end else begin
            cmask = {1'b1, 1'b1, cur_col >= c3zp_pkg::WID_W'(2)};
            rmask = {cur_row < h_eff, 1'b1, cur_row >= c3zp_pkg::DIM_W'(2)};
        end

        if ((cur_col == '0) && (cur_row == h_p1)) begin
            n_col = '0;
            n_row = '0;
        end else if (({1'b0, cur_col} + (c3zp_pkg::WID_W + 1)'(1)) >= {1'b0, w_eff}) begin
            n_col = '0;
            n_row = c3zp_pkg::DIM_W'(cur_row + c3zp_pkg::DIM_W'(1));
        end else begin
            n_col = c3zp_pkg::WID_W'(cur_col + c3zp_pkg::WID_W'(1));
            n_row = cur_row;
        end
    end

    // Second stage: line store data, with forwarding when the previous item hit the same column
    always_comb begin
        up_e  = r_s1_byp ? r_byp_up  : r_up_rd;
        mid_e = r_s1_byp ? r_byp_mid : r_mid_rd;
        new_col = {r_s1_pix, mid_e, up_e};
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                o_job.pix[k*3+j] = '0;
                if (r_s1_cmask[k] && r_s1_rmask[j]) begin
                    if (k == 0) begin
                        o_job.pix[k*3+j] = r_win[1][j];
                    end else if (k == 1) begin
                        o_job.pix[k*3+j] = r_win[2][j];
                    end else begin
                        o_job.pix[k*3+j] = new_col[j];
                    end
                end
            end
        end
        o_job.last  = r_s1_last;
        o_job_valid = r_s1_valid && r_s1_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_s1_valid) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= new_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= addr;
            r_s1_pix   <= pix_in;
            r_s1_emit  <= row_end || in_row;
            r_s1_last  <= row_end && (cur_row == h_p1);
            r_s1_cmask <= cmask;
            r_s1_rmask <= rmask;
            r_s1_byp   <= r_s1_valid && (r_s1_addr == addr);
            r_byp_up   <= mid_e;
            r_byp_mid  <= r_s1_pix;
        end
    end

    // Line stores: read on acceptance, read-modify-write completed from the registered item (r_s1)
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_rd  <= r_line_upper[addr];
            r_mid_rd <= r_line_lower[addr];
        end
        if (r_s1_valid) begin
            r_line_upper[r_s1_addr] <= mid_e;
            r_line_lower[r_s1_addr] <= r_s1_pix;
        end
    end

endmodule

// ===== design/c3zp_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps

module c3zp_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  c3zp_pkg::t_job              i_job,
    input  logic                        i_pop,
    output logic                        o_valid,
    output c3zp_pkg::t_job              o_job,
    output logic [c3zp_pkg::QCNT_W-1:0] o_free
);

    c3zp_pkg::t_job                r_mem [c3zp_pkg::QDEPTH];
    logic [c3zp_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [c3zp_pkg::QCNT_W-1:0]   r_cnt;
    logic                          do_push, do_pop;

    assign o_valid = r_cnt != '0;
    assign o_job   = r_mem[r_rd];
    assign o_free  = c3zp_pkg::QCNT_W'(c3zp_pkg::QDEPTH) - r_cnt;
    assign do_push = i_push && (r_cnt != c3zp_pkg::QCNT_W'(c3zp_pkg::QDEPTH));
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == c3zp_pkg::QPTR_W'(c3zp_pkg::QDEPTH - 1)) ? '0
                      : r_wr + c3zp_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == c3zp_pkg::QPTR_W'(c3zp_pkg::QDEPTH - 1)) ? '0
                      : r_rd + c3zp_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + c3zp_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - c3zp_pkg::QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== design/c3zp_back.sv =====
// Back end: nine products, column sums, total and arithmetic shift into the output register.
`timescale 1ns / 1ps

module c3zp_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_job_valid,
    input  c3zp_pkg::t_job                      i_job,
    input  c3zp_pkg::t_cfg                      i_cfg,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [c3zp_pkg::RES_W-1:0]   o_filtered,
    output logic                                o_last
);

    logic signed [c3zp_pkg::PROD_W-1:0]   prod [3][3];
    logic signed [c3zp_pkg::PROD_W-1:0]   r_p_prod [3][3];
    logic                                 r_p_valid, r_p_last;
    logic signed [c3zp_pkg::COLSUM_W-1:0] col_sum [3];
    logic signed [c3zp_pkg::COLSUM_W-1:0] r_s_sum [3];
    logic                                 r_s_valid, r_s_last;
    logic signed [c3zp_pkg::RES_W-1:0]    total;
    logic signed [c3zp_pkg::RES_W-1:0]    r_o_filtered;
    logic                                 r_o_valid, r_o_last;
    logic                                 en;

    // Whole pipe moves unless a finished result is held up
    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && i_job_valid;

    // Flipped kernel: column k, row j meets tap (2-j, 2-k)
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                prod[k][j] = c3zp_pkg::PROD_W'($signed({1'b0, i_job.pix[k*3+j]}))
                           * c3zp_pkg::PROD_W'(c3zp_pkg::kernel_tap(i_cfg, 2 - j, 2 - k));
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            col_sum[k] = c3zp_pkg::COLSUM_W'(r_p_prod[k][0])
                       + c3zp_pkg::COLSUM_W'(r_p_prod[k][1])
                       + c3zp_pkg::COLSUM_W'(r_p_prod[k][2]);
        end
        total = c3zp_pkg::RES_W'(r_s_sum[0]) + c3zp_pkg::RES_W'(r_s_sum[1])
              + c3zp_pkg::RES_W'(r_s_sum[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= i_job_valid;
            r_s_valid <= r_p_valid;
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_prod     <= prod;
            r_p_last     <= i_job.last;
            r_s_sum      <= col_sum;
            r_s_last     <= r_p_last;
            r_o_filtered <= total >>> i_cfg.shift;
            r_o_last     <= r_s_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_filtered = r_o_filtered;
    assign o_last     = r_o_last;

endmodule

// ===== design/conv3x3_zero_padded_core.sv =====
// Top level of the streaming 3x3 zero-padded convolution core.
`timescale 1ns / 1ps
// Streaming 3x3 convolution (kernel flipped in both axes, zero outside the image) over
// 8-bit grey pixels in raster order. One item is taken per clock, sustained, as long as
// results are taken at the same pace; items keep being taken while a result waits, until
// the four-entry job queue is full. The pace is set by the line-store read-modify-write,
// which takes one column per clock. A pixel's result leaves width+1 items after it goes
// in, and then passes the store read, window/mask stage, job queue, products, column
// sums, total and shift into the output register. After the frame, width+1 flush items
// drain the last row; last_of_frame marks the result for the bottom-right pixel. The
// first width+1 items of a frame give no result, every later one gives exactly one.
// Registers (index: meaning): 0/1/2 kernel rows top/mid/bottom, three signed taps each,
// left tap in the low byte; 3 arithmetic right shift of each sum; 4 image width, clamped
// to 1..512; 5 image height, clamped to 1..1022. Writes to other indexes are dropped;
// writes must only be made while the core is idle; the core does not enforce it. The line
// stores are not cleared at reset; every tap that could read an unwritten entry is masked.
`include "conv3x3_zero_padded_core_assert.svh"

module conv3x3_zero_padded_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [c3zp_pkg::PIX_W-1:0]          i_pixel,
    input  logic                                i_flush,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [c3zp_pkg::RES_W-1:0]   o_filtered,
    output logic                                o_last_of_frame,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [c3zp_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [c3zp_pkg::COEF_W-1:0]         i_cfg_data
);

    c3zp_pkg::t_cfg                 r_cfg, n_cfg;
    logic                           fe_job_valid;
    c3zp_pkg::t_job                 fe_job;
    logic                           q_valid;
    c3zp_pkg::t_job                 q_job;
    logic [c3zp_pkg::QCNT_W-1:0]    q_free;
    logic                           be_pop;

    // Register file: the write channel is always ready, so a write transfer always completes
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                c3zp_pkg::REG_COEF_TOP: n_cfg.coef_top = i_cfg_data;
                c3zp_pkg::REG_COEF_MID: n_cfg.coef_mid = i_cfg_data;
                c3zp_pkg::REG_COEF_BOT: n_cfg.coef_bot = i_cfg_data;
                c3zp_pkg::REG_SHIFT:    n_cfg.shift    = i_cfg_data[c3zp_pkg::SHIFT_W-1:0];
                c3zp_pkg::REG_WIDTH:    n_cfg.width    = i_cfg_data[c3zp_pkg::DIM_W-1:0];
                c3zp_pkg::REG_HEIGHT:   n_cfg.height   = i_cfg_data[c3zp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_top <= '0;
            r_cfg.coef_mid <= '0;
            r_cfg.coef_bot <= '0;
            r_cfg.shift    <= '0;
            r_cfg.width    <= c3zp_pkg::DIM_W'(c3zp_pkg::WIDTH_RESET);
            r_cfg.height   <= c3zp_pkg::DIM_W'(c3zp_pkg::HEIGHT_RESET);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: positions, line stores, window, masking
    c3zp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pixel     (i_pixel),
        .i_flush     (i_flush),
        .i_cfg       (r_cfg),
        .i_q_free    (q_free),
        .o_job_valid (fe_job_valid),
        .o_job       (fe_job)
    );

    // Decoupling queue; the front reserves room before taking an item
    c3zp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_job_valid),
        .i_job   (fe_job),
        .i_pop   (be_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_free  (q_free)
    );

    // Back: multiply-accumulate and shift
    c3zp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .i_cfg       (r_cfg),
        .o_pop       (be_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_filtered  (o_filtered),
        .o_last      (o_last_of_frame)
    );

    // A job leaving the front always finds a free queue slot
    `C3ZP_ASSERT_NOW(a_job_has_slot, fe_job_valid, q_free != '0)
    // An accepted pixel still has its slot reserved in the following cycle
    `C3ZP_ASSERT_NEXT(a_accept_reserves, i_valid && o_ready, q_free != '0)

endmodule
